// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
package deq_pkg;

	localparam int unsigned DEF_DEPTH = 1024;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned COUNT_W   = 11;
	localparam int unsigned ACTION_W  = 3;

	localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_QUERY      = 3'd4;

	localparam logic [WORD_W-1:0] NEG_ONE = '1;

	// Controller to datapath
	typedef struct packed {
		logic load;   // capture input word
		logic exec;   // move pointers, write or read popped entry
		logic view;   // capture popped, read front and back
		logic emit;   // load output register
	} deq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_stall;  // output register holds a word not yet taken
	} deq_sts_t;

endpackage

// ===== rtl/deq_ctrl.sv =====
// Sequencing state machine for the double-ended queue.
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  deq_pkg::deq_sts_t sts,
	output deq_pkg::deq_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_VIEW,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_EXEC;
				end
				ST_EXEC: state_q <= ST_VIEW;
				ST_VIEW: state_q <= ST_DONE;
				ST_DONE: begin
					if (!sts.out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec = (state_q == ST_EXEC);
		cmd.view = (state_q == ST_VIEW);
		cmd.emit = (state_q == ST_DONE) && !sts.out_stall;
	end

endmodule

// ===== rtl/deq_datapath.sv =====
// Ring buffer storage, pointers, occupancy and output register of the queue.
module deq_datapath #(
	parameter int unsigned DEPTH = deq_pkg::DEF_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  deq_pkg::deq_cmd_t               cmd,
	output deq_pkg::deq_sts_t               sts,
	input  logic [deq_pkg::ACTION_W-1:0]    in_action,
	input  logic [deq_pkg::WORD_W-1:0]      in_value,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [deq_pkg::WORD_W-1:0]      out_popped,
	output logic                            out_pop_ok,
	output logic                            out_overflow,
	output logic [deq_pkg::COUNT_W-1:0]     out_count,
	output logic                            out_is_empty,
	output logic [deq_pkg::WORD_W-1:0]      out_front,
	output logic [deq_pkg::WORD_W-1:0]      out_back
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned W  = deq_pkg::WORD_W;

	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [deq_pkg::ACTION_W-1:0] action_q;
	logic [W-1:0]                 value_q;
	logic [AW-1:0]                head_q, tail_q;
	logic [CW-1:0]                count_q;
	logic [W-1:0]                 mem_q [DEPTH];
	logic [W-1:0]                 rd_a_q, rd_b_q;
	logic [W-1:0]                 popped_q;
	logic                         pop_ok_q, ovf_q, m_tvalid_q;

	logic [AW-1:0] head_up, head_dn, tail_up, tail_dn;
	logic          full, empty;
	logic          do_pushf, do_pushb, do_popf, do_popb, push_drop;
	logic          wr_en, rd_a_en, rd_b_en;
	logic [AW-1:0] wr_addr, rd_a_addr;

	always_comb begin
		head_up = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
		head_dn = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
		tail_up = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
		tail_dn = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);
		full    = (count_q == FULL_CNT);
		empty   = (count_q == '0);

		do_pushf  = 1'b0;
		do_pushb  = 1'b0;
		do_popf   = 1'b0;
		do_popb   = 1'b0;
		push_drop = 1'b0;
		case (action_q)
			deq_pkg::ACT_PUSH_FRONT: begin
				do_pushf  = !full;
				push_drop = full;
			end
			deq_pkg::ACT_PUSH_BACK: begin
				do_pushb  = !full;
				push_drop = full;
			end
			deq_pkg::ACT_POP_FRONT: do_popf = !empty;
			deq_pkg::ACT_POP_BACK:  do_popb = !empty;
			default: ;  // query and unused codes
		endcase

		wr_en     = cmd.exec && (do_pushf || do_pushb);
		wr_addr   = do_pushf ? head_dn : tail_q;
		rd_a_en   = (cmd.exec && (do_popf || do_popb)) || cmd.view;
		// view reads the front; exec reads the popped slot
		rd_a_addr = (cmd.exec && do_popb) ? tail_dn : head_q;
		rd_b_en   = cmd.view;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				if (do_pushf || do_popb) begin
					if (do_pushf) head_q <= head_dn;
					else          tail_q <= tail_dn;
				end
				if (do_pushb) tail_q <= tail_up;
				if (do_popf)  head_q <= head_up;
				if (do_pushf || do_pushb) count_q <= count_q + CW'(1);
				if (do_popf || do_popb)   count_q <= count_q - CW'(1);
			end
			if (cmd.emit)      m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			value_q  <= in_value;
		end
		if (wr_en)   mem_q[wr_addr] <= value_q;
		if (rd_a_en) rd_a_q <= mem_q[rd_a_addr];
		if (rd_b_en) rd_b_q <= mem_q[tail_dn];
		if (cmd.exec) begin
			pop_ok_q <= do_popf || do_popb;
			ovf_q    <= push_drop;
		end
		if (cmd.view) popped_q <= pop_ok_q ? rd_a_q : deq_pkg::NEG_ONE;
		if (cmd.emit) begin
			out_popped   <= popped_q;
			out_pop_ok   <= pop_ok_q;
			out_overflow <= ovf_q;
			out_count    <= deq_pkg::COUNT_W'(count_q);
			out_is_empty <= empty;
			out_front    <= empty ? deq_pkg::NEG_ONE : rd_a_q;
			out_back     <= empty ? deq_pkg::NEG_ONE : rd_b_q;
		end
	end

	assign m_tvalid      = m_tvalid_q;
	assign sts.out_stall = m_tvalid_q && !m_tready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("occupancy above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && (do_pushf || do_pushb)) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("accepted push did not raise occupancy");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(out_pop_ok && out_overflow))
		else $error("pop_ok and overflow both set");

	a_empty_view: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_is_empty) |-> (out_front == deq_pkg::NEG_ONE
			&& out_back == deq_pkg::NEG_ONE))
		else $error("empty result shows an entry");

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue.
//
// Channel   Dir  Bits  Contents
// s_*       in   3+32  s_tuser = action, s_tdata = value
// m_*       out  112   result word, fields listed at m_tdata
//
// After acceptance a word's result passes through pointer update with one memory
// access, front/back read and output load; the next word is accepted after the
// output load. The two registered memory reads run in sequence, so a new word is
// not accepted until the previous one has finished these steps.
// Reset clears pointers, occupancy and the output valid; storage is not cleared.
// A new word is accepted while the previous result waits in the output register;
// a stalled output holds the next result in its final step.
module double_ended_queue #(
	parameter int unsigned DEPTH = deq_pkg::DEF_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] value
	input  logic [2:0]   s_tuser,   // [2:0] action
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] popped, [32] pop_ok, [33] overflow, [44:34] count, [45] is_empty,
	// [77:46] front_value, [109:78] back_value, [111:110] zero
	output logic [111:0] m_tdata
);

	deq_pkg::deq_cmd_t cmd;
	deq_pkg::deq_sts_t sts;

	logic [31:0] popped, front_value, back_value;
	logic        pop_ok, overflow, is_empty;
	logic [10:0] count;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	deq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_action    (s_tuser),
		.in_value     (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.out_popped   (popped),
		.out_pop_ok   (pop_ok),
		.out_overflow (overflow),
		.out_count    (count),
		.out_is_empty (is_empty),
		.out_front    (front_value),
		.out_back     (back_value)
	);

	assign m_tdata = {2'b00, back_value, front_value, is_empty, count, overflow, pop_ok,
		popped};

endmodule

// ===== dv/double_ended_queue_tb.sv =====
// Self-checking testbench for the double_ended_queue ring-buffer deque.
`timescale 1ns / 100ps

module double_ended_queue_tb;

	localparam int unsigned DQ_DEPTH     = deq_pkg::DEF_DEPTH;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          SETTLE_TICKS = 16;

	// Result word as packed on m_tdata, popped in the low bits
	typedef struct packed {
		logic [deq_pkg::WORD_W-1:0]  back_value;
		logic [deq_pkg::WORD_W-1:0]  front_value;
		logic                        is_empty;
		logic [deq_pkg::COUNT_W-1:0] count;
		logic                        overflow;
		logic                        pop_ok;
		logic [deq_pkg::WORD_W-1:0]  popped;
	} dq_result_t;

	typedef struct {
		logic [deq_pkg::ACTION_W-1:0] action;
		logic [deq_pkg::WORD_W-1:0]   value;
		int                           gap_pct;
		int                           stall_pct;
		bit                           hold;   // wait for all results before sending
	} dq_word_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [deq_pkg::WORD_W-1:0]   s_tdata  = '0;
	logic [deq_pkg::ACTION_W-1:0] s_tuser  = deq_pkg::ACT_QUERY;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [111:0]                 m_tdata;

	double_ended_queue #(.DEPTH(DQ_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	dq_word_t    pending_words[$];
	dq_result_t  expected_results[$];
	dq_word_t    next_word;
	int          error_count  = 0;
	int          cycle_count  = 0;
	int          rx_stall_pct = 0;

	// Predictor state
	logic [deq_pkg::WORD_W-1:0] deq_mem [DQ_DEPTH];
	int unsigned                deq_head = 0;
	int unsigned                deq_tail = 0;
	int unsigned                deq_fill = 0;

	// Stimulus-side bookkeeping
	int unsigned gen_fill  = 0;
	int          gen_gap   = 0;
	int          gen_stall = 0;
	bit          gen_hold  = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic dq_result_t deque_step(input logic [deq_pkg::ACTION_W-1:0] act,
	                                           input logic [deq_pkg::WORD_W-1:0] val);
		dq_result_t r;
		r.popped   = deq_pkg::NEG_ONE;
		r.pop_ok   = 1'b0;
		r.overflow = 1'b0;
		case (act)
			deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
				if (deq_fill >= DQ_DEPTH) begin
					r.overflow = 1'b1;
				end else if (act == deq_pkg::ACT_PUSH_FRONT) begin
					deq_head = (deq_head + DQ_DEPTH - 1) % DQ_DEPTH;
					deq_mem[deq_head] = val;
					deq_fill++;
				end else begin
					deq_mem[deq_tail] = val;
					deq_tail = (deq_tail + 1) % DQ_DEPTH;
					deq_fill++;
				end
			end
			deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
				if (deq_fill != 0) begin
					if (act == deq_pkg::ACT_POP_FRONT) begin
						r.popped = deq_mem[deq_head];
						deq_head = (deq_head + 1) % DQ_DEPTH;
					end else begin
						deq_tail = (deq_tail + DQ_DEPTH - 1) % DQ_DEPTH;
						r.popped = deq_mem[deq_tail];
					end
					r.pop_ok = 1'b1;
					deq_fill--;
				end
			end
			default: ;  // query and the spare codes leave the deque alone
		endcase
		r.count    = deq_fill[deq_pkg::COUNT_W-1:0];
		r.is_empty = (deq_fill == 0);
		if (deq_fill != 0) begin
			r.front_value = deq_mem[deq_head];
			r.back_value  = deq_mem[(deq_tail + DQ_DEPTH - 1) % DQ_DEPTH];
		end else begin
			r.front_value = deq_pkg::NEG_ONE;
			r.back_value  = deq_pkg::NEG_ONE;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what,
	                               input logic [deq_pkg::WORD_W-1:0] got,
	                               input logic [deq_pkg::WORD_W-1:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic check_result(input logic [111:0] word);
		dq_result_t got;
		dq_result_t want;
		got = dq_result_t'(word[109:0]);
		if (expected_results.size() == 0) begin
			report_mismatch("result word with nothing expected", word[31:0], '0);
			return;
		end
		want = expected_results.pop_front();
		if (got.popped !== want.popped)
			report_mismatch("popped", got.popped, want.popped);
		if (got.pop_ok !== want.pop_ok)
			report_mismatch("pop_ok", deq_pkg::WORD_W'(got.pop_ok),
				deq_pkg::WORD_W'(want.pop_ok));
		if (got.overflow !== want.overflow)
			report_mismatch("overflow", deq_pkg::WORD_W'(got.overflow),
				deq_pkg::WORD_W'(want.overflow));
		if (got.count !== want.count)
			report_mismatch("count", deq_pkg::WORD_W'(got.count),
				deq_pkg::WORD_W'(want.count));
		if (got.is_empty !== want.is_empty)
			report_mismatch("is_empty", deq_pkg::WORD_W'(got.is_empty),
				deq_pkg::WORD_W'(want.is_empty));
		if (got.front_value !== want.front_value)
			report_mismatch("front_value", got.front_value, want.front_value);
		if (got.back_value !== want.back_value)
			report_mismatch("back_value", got.back_value, want.back_value);
	endtask

	// Driver: predicts on each accepted word, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= deq_pkg::ACT_QUERY;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(deque_step(s_tuser, s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0
				    && !(pending_words[0].hold && expected_results.size() != 0)
				    && $urandom_range(0, 99) >= pending_words[0].gap_pct) begin
					next_word = pending_words.pop_front();
					s_tvalid     <= 1'b1;
					s_tdata      <= next_word.value;
					s_tuser      <= next_word.action;
					rx_stall_pct <= next_word.stall_pct;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [deq_pkg::WORD_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return deq_pkg::NEG_ONE;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic set_idle(input int mode);
		case (mode % 4)
			0: begin gen_gap = 0;  gen_stall = 0;  end
			1: begin gen_gap = 68; gen_stall = 0;  end
			2: begin gen_gap = 0;  gen_stall = 68; end
			default: begin gen_gap = 24; gen_stall = 24; end
		endcase
	endtask

	task automatic add_word(input logic [deq_pkg::ACTION_W-1:0] act,
	                        input logic [deq_pkg::WORD_W-1:0] val);
		dq_word_t w;
		w.action    = act;
		w.value     = val;
		w.gap_pct   = gen_gap;
		w.stall_pct = gen_stall;
		w.hold      = gen_hold;
		gen_hold    = 1'b0;
		pending_words.push_back(w);
		if ((act == deq_pkg::ACT_PUSH_FRONT || act == deq_pkg::ACT_PUSH_BACK)
		    && gen_fill < DQ_DEPTH)
			gen_fill++;
		else if ((act == deq_pkg::ACT_POP_FRONT || act == deq_pkg::ACT_POP_BACK)
		         && gen_fill != 0)
			gen_fill--;
	endtask

	function automatic logic [deq_pkg::ACTION_W-1:0] any_push();
		return $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT;
	endfunction

	function automatic logic [deq_pkg::ACTION_W-1:0] any_pop();
		return $urandom_range(0, 1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT;
	endfunction

	// Mixed traffic; push odds lean on the fill level to keep it wandering
	task automatic random_run(input int n);
		int r;
		int push_pct;
		logic [deq_pkg::ACTION_W-1:0] act;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			push_pct = (gen_fill < 4) ? 65 : ((gen_fill > 64) ? 30 : 47);
			if (r < 6)
				act = deq_pkg::ACTION_W'($urandom_range(deq_pkg::ACT_QUERY,
					(1 << deq_pkg::ACTION_W) - 1));
			else if (r < 6 + push_pct)
				act = any_push();
			else
				act = any_pop();
			add_word(act, pick_value());
		end
	endtask

	initial begin
		// Directed: empty pops, extreme values, spare codes, single-entry cases
		set_idle(0);
		add_word(deq_pkg::ACT_QUERY, 32'h0000_0000);
		add_word(deq_pkg::ACT_POP_FRONT, 32'hffff_ffff);
		add_word(deq_pkg::ACT_POP_BACK, 32'h1234_5678);
		add_word(deq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
		add_word(deq_pkg::ACT_PUSH_BACK, 32'h7fff_ffff);
		add_word(deq_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
		add_word(deq_pkg::ACT_PUSH_BACK, 32'hffff_ffff);
		for (int c = deq_pkg::ACT_QUERY + 1; c < (1 << deq_pkg::ACTION_W); c++)
			add_word(deq_pkg::ACTION_W'(c), 32'haaaa_5555);
		add_word(deq_pkg::ACT_POP_FRONT, 32'h5555_aaaa);
		add_word(deq_pkg::ACT_POP_BACK, 32'h0);
		add_word(deq_pkg::ACT_POP_FRONT, 32'h0);
		add_word(deq_pkg::ACT_POP_BACK, 32'h0);
		add_word(deq_pkg::ACT_POP_BACK, 32'h0);
		add_word(deq_pkg::ACT_PUSH_BACK, 32'h5555_aaaa);
		add_word(deq_pkg::ACT_POP_FRONT, 32'h0);
		add_word(deq_pkg::ACT_PUSH_FRONT, 32'h0000_0001);
		add_word(deq_pkg::ACT_POP_BACK, 32'h0);
		add_word(deq_pkg::ACT_QUERY, 32'hffff_ffff);

		for (int seg = 0; seg < 8; seg++) begin
			set_idle(seg);
			gen_hold = (seg == 2 || seg == 5);
			random_run(80);
		end

		// Drain past empty
		set_idle(1);
		gen_hold = 1'b1;
		while (gen_fill != 0)
			add_word(any_pop(), pick_value());
		for (int i = 0; i < 3; i++)
			add_word(any_pop(), pick_value());
		set_idle(0);
		random_run(20);

		while (pending_words.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
